[rtl/piq_pkg.sv]
// Shared types and constants of the proportional insert queue.
// Used by piq_ctrl, piq_datapath and proportional_insert_queue; no dependencies.
`default_nettype none

package piq_pkg;

  // Request action codes
  localparam logic ActEnq = 1'b0;
  localparam logic ActDeq = 1'b1;

  // Priority scale: priority 16 inserts at the back
  localparam logic [4:0] PrioScale = 5'd16;
  localparam int unsigned PrioShift = 4;

  typedef enum logic [1:0] {
    StatEnq   = 2'd0,
    StatDeq   = 2'd1,
    StatEmpty = 2'd2,
    StatFull  = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;   // capture the incoming request
    logic insert;  // insert the held value into the queue
    logic pop;     // remove the front entry
    logic reject;  // leave the queue alone, report empty or full
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_deq;  // held request is a dequeue
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

[rtl/proportional_insert_queue.sv]
// Proportional insert queue: bounded queue of signed 32-bit values whose
// insert depth follows a priority. Depends on piq_pkg, piq_ctrl, piq_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request: action_i
//   selects enqueue or dequeue, value_in_i is the value to insert and
//   priority_req_i the insert priority (0 front .. 16 back, larger clamps
//   to 16). An enqueue lands at min(prio * (count + 1) / 16, count).
//   Output channel (out_valid_o / out_ready_i) returns one response per
//   request: removed front value (else zero), status code and occupancy.
//   Order: the request register captures the request, the execute state
//   updates the entry array and loads the response register, and the
//   response is valid in the send state that follows.
//   A new request is taken only after the response has left; the
//   controller runs capture, execute and send in turn, and the entry
//   array shifts entries in place in the execute state.
//   Stall: while out_ready_i is low the response holds and no new request is
//   taken; in_ready_o stays low until the response leaves.
//   Reset: the queue comes up empty and idle, ready for a request. Entry
//   contents are left as they are and are only read after being written.
//   Full enqueue and empty dequeue leave the queue unchanged.
`default_nettype none

module proportional_insert_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic signed [31:0] value_in_i,
  input  wire logic [4:0]         priority_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      value_out_o,
  output logic [1:0]              status_o,
  output logic [4:0]              occupancy_o
);

  // Command and status between the sequencer and the datapath
  piq_pkg::cmd_t  cmd;
  piq_pkg::stat_t stat;

  // Sequencer: capture the request, execute once, hold the response
  piq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Entry array, count, insert position and response register
  piq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (action_i),
    .value_in_i     (value_in_i),
    .priority_req_i (priority_req_i),
    .value_out_o    (value_out_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

`default_nettype wire

[rtl/piq_ctrl.sv]
// Controller of the proportional insert queue: one-hot sequencer that
// accepts a request, issues one execute command and holds the response.
// Depends on piq_pkg.
`default_nettype none

module piq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire piq_pkg::stat_t stat_i,
  output piq_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StSend = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StExec;
        end
      end
      StExec: begin
        if (stat_i.is_deq) begin
          cmd_o.pop    = !stat_i.empty;
          cmd_o.reject = stat_i.empty;
        end else begin
          cmd_o.insert = !stat_i.full;
          cmd_o.reject = stat_i.full;
        end
        state_d = StSend;
      end
      StSend: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StSend);

endmodule

`default_nettype wire

[rtl/piq_datapath.sv]
// Datapath of the proportional insert queue: request register, shifting
// entry array, occupancy count, insert position and response register.
// Depends on piq_pkg.
`default_nettype none

module piq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire piq_pkg::cmd_t      cmd_i,
  output piq_pkg::stat_t          stat_o,
  input  wire logic               action_i,
  input  wire logic signed [31:0] value_in_i,
  input  wire logic [4:0]         priority_req_i,
  output logic signed [31:0]      value_out_o,
  output logic [1:0]              status_o,
  output logic [4:0]              occupancy_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned ProdW = CntW + 5;

  // Request register
  logic               act_q;
  logic signed [31:0] val_q;
  logic [4:0]         prio_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      val_q  <= value_in_i;
      prio_q <= priority_req_i;
    end
  end

  // Occupancy
  logic [CntW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.insert) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_q <= count_q - CntW'(1);
    end
  end

  assign stat_o.is_deq = (act_q == piq_pkg::ActDeq);
  assign stat_o.full   = (count_q == CntW'(DEPTH));
  assign stat_o.empty  = (count_q == '0);

  // Insert position: min(prio * (count + 1) / 16, count)
  logic [4:0]       prio_c;
  logic [CntW-1:0]  newcnt;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] pos_raw;
  logic [CntW-1:0]  pos;

  always_comb begin
    prio_c  = (prio_q > piq_pkg::PrioScale) ? piq_pkg::PrioScale : prio_q;
    newcnt  = count_q + CntW'(1);
    prod    = ProdW'(prio_c) * ProdW'(newcnt);
    pos_raw = prod >> piq_pkg::PrioShift;
    pos     = (pos_raw > ProdW'(count_q)) ? count_q : pos_raw[CntW-1:0];
  end

  // Entry array, front at index 0; each entry sees only its neighbors
  logic signed [31:0] entries_q [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam logic [CntW-1:0] Idx = CntW'(g);
    if (g == 0) begin : g_front
      always_ff @(posedge clk_i) begin
        if (cmd_i.insert && (pos == Idx)) begin
          entries_q[g] <= val_q;
        end else if (cmd_i.pop && (DEPTH > 1)) begin
          entries_q[g] <= entries_q[1];
        end
      end
    end else if (g == DEPTH - 1) begin : g_back
      always_ff @(posedge clk_i) begin
        if (cmd_i.insert) begin
          if (pos == Idx) begin
            entries_q[g] <= val_q;
          end else if ((Idx > pos) && (Idx <= count_q)) begin
            entries_q[g] <= entries_q[g-1];
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk_i) begin
        if (cmd_i.insert) begin
          if (pos == Idx) begin
            entries_q[g] <= val_q;
          end else if ((Idx > pos) && (Idx <= count_q)) begin
            entries_q[g] <= entries_q[g-1];
          end
        end else if (cmd_i.pop) begin
          entries_q[g] <= entries_q[g+1];
        end
      end
    end
  end

  // Response register
  logic signed [31:0] res_val_q;
  piq_pkg::status_e   res_stat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      res_val_q  <= '0;
      res_stat_q <= piq_pkg::StatEnq;
    end else if (cmd_i.pop) begin
      res_val_q  <= entries_q[0];
      res_stat_q <= piq_pkg::StatDeq;
    end else if (cmd_i.reject) begin
      res_val_q  <= '0;
      res_stat_q <= stat_o.is_deq ? piq_pkg::StatEmpty : piq_pkg::StatFull;
    end
  end

  logic [ProdW-1:0] count_ext;
  assign count_ext   = ProdW'(count_q);
  assign value_out_o = res_val_q;
  assign status_o    = res_stat_q;
  assign occupancy_o = count_ext[4:0];

endmodule

`default_nettype wire

[verif/tb_proportional_insert_queue.sv]
// Self-checking testbench for proportional_insert_queue: drives requests on the
// valid/ready input channel and compares every response with a queue predictor.
// Depends on piq_pkg and the queue RTL (proportional_insert_queue, piq_ctrl, piq_datapath).
`timescale 1ns / 1ps

module tb_proportional_insert_queue;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CLK_HALF    = 6;
  localparam int unsigned RAND_ITEMS  = 825;
  localparam int unsigned HOLD_AT     = 300;    // request count that triggers the long hold-off
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PAUSE_AT    = 550;    // request count where the sender pauses
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct {
    logic signed [31:0] value;
    piq_pkg::status_e   status;
    logic [4:0]         occupancy;
  } response_t;

  // Predict the queue contents and hold the responses still owed by the block.
  class queue_scoreboard;
    logic signed [31:0] slots [QUEUE_DEPTH];
    int unsigned        held;
    response_t          owed_responses [$];
    int unsigned        mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_responses.size();
    endfunction

    // Apply one accepted request to the shadow queue and queue up its response.
    function void predict_response(logic act, logic signed [31:0] val, logic [4:0] prio);
      response_t   r;
      int unsigned p;
      int unsigned slot;
      int unsigned grown;
      r.value = '0;
      if (act == piq_pkg::ActEnq) begin
        if (held >= QUEUE_DEPTH) begin
          r.status = piq_pkg::StatFull;
        end else begin
          grown = held + 1;
          p     = (prio > piq_pkg::PrioScale) ? 32'(piq_pkg::PrioScale) : 32'(prio);
          slot  = (p * grown) / 32'(piq_pkg::PrioScale);
          if (slot > held) slot = held;
          for (int i = int'(held); i > int'(slot); i--) slots[i] = slots[i-1];
          slots[slot] = val;
          held        = grown;
          r.status    = piq_pkg::StatEnq;
        end
      end else if (held == 0) begin
        r.status = piq_pkg::StatEmpty;
      end else begin
        r.value = slots[0];
        for (int i = 1; i < int'(held); i++) slots[i-1] = slots[i];
        held     = held - 1;
        r.status = piq_pkg::StatDeq;
      end
      r.occupancy = held[4:0];
      owed_responses.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_response(logic signed [31:0] v, logic [1:0] st, logic [4:0] occ);
      response_t e;
      if (owed_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response value %0d status %0d occupancy %0d",
                                  v, st, occ));
        return;
      end
      e = owed_responses.pop_front();
      if (v !== e.value)
        report_mismatch($sformatf("value_out %0d, expected %0d", v, e.value));
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
      if (occ !== e.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", occ, e.occupancy));
    endtask

    task flush_leftovers();
      if (owed_responses.size() != 0)
        report_mismatch($sformatf("%0d responses never arrived", owed_responses.size()));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               action_i;
  logic signed [31:0] value_in_i;
  logic [4:0]         priority_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] value_out_o;
  logic [1:0]         status_o;
  logic [4:0]         occupancy_o;

  queue_scoreboard board = new();

  int unsigned requests_taken = 0;
  int unsigned cycle_count    = 0;
  bit          send_steady    = 0;   // sender offers back to back while set
  bit          recv_steady    = 0;   // receiver adds no random stalls while set

  proportional_insert_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .value_in_i     (value_in_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_out_o    (value_out_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sh00000000;
      3:       return 32'shffffffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal priorities, a quarter over the whole 5-bit range to hit the clamp.
  function automatic logic [4:0] pick_priority();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 16));
  endfunction

  // Offer one request: idle first, then hold valid and payload until taken.
  task automatic offer(logic act, logic signed [31:0] val, logic [4:0] prio);
    int unsigned gap;
    gap = pick_gap(send_steady);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    value_in_i     <= val;
    priority_req_i <= prio;
    do @(posedge clk_i); while (!in_ready_o);
    // The request was taken at this edge: advance the prediction.
    requests_taken++;
    board.predict_response(act, val, prio);
  endtask

  // Receiver: check each response taken at an edge, then pick the next ready.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned steady_left;
    bit          hold_done;
    stall_left  = 0;
    steady_left = 0;
    hold_done   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        board.check_response(value_out_o, status_o, occupancy_o);
      // Toggle between stretches of steady ready and stretches of random stalls.
      if (steady_left == 0) begin
        recv_steady = !recv_steady;
        steady_left = $urandom_range(50, 250);
      end else begin
        steady_left--;
      end
      if (!hold_done && requests_taken >= HOLD_AT) begin
        // Hold off for a long stretch so the block backs up and stalls its input.
        hold_done  = 1;
        stall_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap(recv_steady);
      end
    end
  end

  // Watchdog: end the run if the traffic never completes.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_proportional_insert_queue NOT OK");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [4:0]  dir_prio [17];
    int unsigned bias;
    int unsigned seg_left;
    logic        act;
    bit          paused;
    dir_prio = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd8, 5'd1, 5'd15, 5'd4,
                 5'd12, 5'd0, 5'd16, 5'd2, 5'd9, 5'd30, 5'd6, 5'd14, 5'd31};
    bias     = 50;
    seg_left = 0;
    paused   = 0;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = piq_pkg::ActEnq;
    value_in_i     = '0;
    priority_req_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dequeue on empty, enqueue at every end and the clamp, fill
    // to the bound, one rejected enqueue, then drain part of the queue.
    offer(piq_pkg::ActDeq, 32'sh12345678, 5'd0);
    for (int k = 0; k < 17; k++) begin
      case (k)
        0:       offer(piq_pkg::ActEnq, 32'sh7fffffff, dir_prio[k]);
        1:       offer(piq_pkg::ActEnq, 32'sh80000000, dir_prio[k]);
        2:       offer(piq_pkg::ActEnq, 32'sh00000000, dir_prio[k]);
        3:       offer(piq_pkg::ActEnq, 32'shffffffff, dir_prio[k]);
        default: offer(piq_pkg::ActEnq, $urandom, dir_prio[k]);
      endcase
    end
    for (int k = 0; k < 7; k++) offer(piq_pkg::ActDeq, $urandom, 5'($urandom_range(0, 31)));

    // Random: segments that lean toward filling, draining or an even mix,
    // so the queue sweeps between empty and full many times.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 85;
          1:       bias = 15;
          default: bias = 50;
        endcase
        send_steady = ($urandom_range(0, 3) == 0);
        seg_left    = $urandom_range(20, 60);
      end
      seg_left--;
      if (!paused && requests_taken >= PAUSE_AT) begin
        // Pause until every owed response has come back.
        paused = 1;
        in_valid_i <= 1'b0;
        while (board.pending() != 0) @(posedge clk_i);
      end
      act = ($urandom_range(0, 99) < bias) ? piq_pkg::ActEnq : piq_pkg::ActDeq;
      offer(act, pick_value(), pick_priority());
    end
    in_valid_i <= 1'b0;

    // Drain: wait for the last responses, then a few cycles for strays.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    board.flush_leftovers();
    if (board.mismatches == 0) begin
      $display("tb_proportional_insert_queue OK");
    end else begin
      $display("tb_proportional_insert_queue NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/piq_pkg.sv
rtl/piq_ctrl.sv
rtl/piq_datapath.sv
rtl/proportional_insert_queue.sv
verif/tb_proportional_insert_queue.sv
